// File: hdl/potential_field_setpoint_step_defines.svh
`ifndef POTENTIAL_FIELD_SETPOINT_STEP_DEFINES_SVH
`define POTENTIAL_FIELD_SETPOINT_STEP_DEFINES_SVH

// Checks on the setpoint block. They sample on clk and hold off while arst_n is low.
`define PFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that one condition is followed by another on the next cycle.
`define PFS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/pfs_pkg.sv
package pfs_pkg;

	localparam int IDX_W = 3;
	localparam int GAIN_W = 31;
	localparam int TICK_W = 4;

	localparam logic [TICK_W-1:0] TICK_PULSE = 4'd10;
	localparam logic [TICK_W-1:0] TICK_LAST = 4'd11;

	typedef enum logic [IDX_W-1:0] {
		REG_GOAL_X,
		REG_GOAL_Y,
		REG_GOAL_Z,
		REG_OBST_X,
		REG_OBST_Y,
		REG_OBST_Z,
		REG_GAIN,
		REG_RADIUS
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		unit_op_t op;
		logic ld;
		logic clr;
		logic stp;
	} unit_ctl_t;

endpackage

// File: hdl/pfs_channels.sv
interface pfs_pos_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pfs_set_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] set_x;
	logic signed [COORD_WIDTH-1:0] set_y;
	logic signed [COORD_WIDTH-1:0] set_z;
	logic climbing;
	logic send_mode_cmd;
	logic send_arm_cmd;

	modport source (output valid, output set_x, output set_y, output set_z,
		output climbing, output send_mode_cmd, output send_arm_cmd, input ready);
	modport sink (input valid, input set_x, input set_y, input set_z,
		input climbing, input send_mode_cmd, input send_arm_cmd, output ready);
endinterface

// File: hdl/pfs_serial_unit.sv
module pfs_serial_unit #(
	parameter int AW = 98
) (
	input logic clk,
	input pfs_pkg::unit_ctl_t ctl,
	input logic [AW-1:0] a,
	input logic [AW-1:0] b,
	output logic [AW-1:0] acc,
	output logic [AW-1:0] quo,
	output logic [AW-1:0] root
);
	import pfs_pkg::*;

	logic [AW-1:0] acc_q;
	logic [AW-1:0] opa_q;
	logic [AW-1:0] opb_q;

	logic [AW-1:0] mul_sum;
	logic [AW:0] dsh;
	logic [AW+1:0] ddiff;
	logic dge;
	logic [AW+1:0] ssh;
	logic [AW+1:0] strial;
	logic [AW+2:0] sdiff;
	logic sge;

	always_comb begin
		mul_sum = acc_q + (opb_q[0] ? opa_q : '0);
		// Restoring division: one quotient bit per cycle while stepping, numerator enters MSB first.
		dsh = {acc_q, opb_q[AW-1]};
		ddiff = {1'b0, dsh} - {2'b00, opa_q};
		dge = !ddiff[AW+1];
		// Digit-by-digit square root: two radicand bits in, one root bit out.
		ssh = {acc_q, opb_q[AW-1:AW-2]};
		strial = {opa_q, 2'b01};
		sdiff = {1'b0, ssh} - {1'b0, strial};
		sge = !sdiff[AW+2];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			opa_q <= a;
			opb_q <= b;
			if (ctl.clr) begin
				acc_q <= '0;
			end
		end else if (ctl.stp) begin
			case (ctl.op)
				OP_MUL: begin
					acc_q <= mul_sum;
					opa_q <= {opa_q[AW-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[AW-1:1]};
				end
				OP_DIV: begin
					acc_q <= dge ? ddiff[AW-1:0] : dsh[AW-1:0];
					opb_q <= {opb_q[AW-2:0], dge};
				end
				OP_SQRT: begin
					acc_q <= sge ? sdiff[AW-1:0] : ssh[AW-1:0];
					opa_q <= {opa_q[AW-2:0], sge};
					opb_q <= {opb_q[AW-3:0], 2'b00};
				end
				default: begin
				end
			endcase
		end
	end

	assign acc = acc_q;
	assign quo = opb_q;
	assign root = opa_q;

endmodule

// File: hdl/potential_field_setpoint_step.sv
// Channel    Dir  Payload
// pos        in   pos_x, pos_y, pos_z
// setpoint   out  set_x, set_y, set_z, climbing, send_mode_cmd, send_arm_cmd
// wr_*       in   register write: wr_en, wr_index, wr_data
//
// One item at a time; pos.ready is high only while the block is idle.
// A climb tick skips the arithmetic and goes straight to the output stage. Otherwise, with
// M = max(COORD_WIDTH, 31 + FRAC_BITS) + 1 and A = 2*M + 2, the work runs on one A-bit shift-add /
// restoring divide / square root unit, one bit per cycle while stepping; repulsion phases run only when it applies.
// The result register lets the next transfer in while the setpoint waits on ready.
// arst_n clears control state and loads the register reset values.
`include "potential_field_setpoint_step_defines.svh"

module potential_field_setpoint_step #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	pfs_pos_if.sink pos,
	pfs_set_if.source setpoint,
	input logic wr_en,
	input logic [pfs_pkg::IDX_W-1:0] wr_index,
	input logic [(COORD_WIDTH > pfs_pkg::GAIN_W ? COORD_WIDTH : pfs_pkg::GAIN_W)-1:0] wr_data
);
	import pfs_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int CWP = CW + 1;
	localparam int WIDE = (CW > GAIN_W + F) ? CW : GAIN_W + F;
	localparam int MW = WIDE + 1;
	localparam int MWP = MW + 1;
	localparam int AW = 2 * MW + 2;
	localparam int SW = ((CW > F + 1) ? CW : F + 1) + 2;
	localparam int CNT_W = $clog2(AW + 2);
	localparam int FP = F + 1;

	localparam longint CMAX_L = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint CMIN_L = -CMAX_L - 1;
	localparam longint CLIMB_RAW = -(longint'(3) <<< F);
	localparam longint GZ_RAW = -(longint'(5) <<< F);
	localparam longint OZ_RAW = longint'(3) <<< F;
	localparam logic signed [CW-1:0] CLIMB_Z = CW'(CLIMB_RAW < CMIN_L ? CMIN_L : CLIMB_RAW);
	localparam logic signed [CW-1:0] GOAL_Z_RST = CW'(GZ_RAW < CMIN_L ? CMIN_L : GZ_RAW);
	localparam logic signed [CW-1:0] OBST_Z_RST = CW'(OZ_RAW > CMAX_L ? CMAX_L : OZ_RAW);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(longint'(3) <<< F);
	localparam logic [GAIN_W-1:0] RAD_RST = GAIN_W'(longint'(2) <<< F);
	localparam logic signed [SW-1:0] SMAX = SW'(CMAX_L);
	localparam logic signed [SW-1:0] SMIN = SW'(CMIN_L);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RSQ,
		S_DSQ,
		S_RMUL,
		S_RDIV,
		S_MSQ,
		S_SQRT,
		S_QDIV,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] ax_q;
	logic [TICK_W-1:0] tick_q;
	logic oval_q;
	logic signed [CW-1:0] oset_q [3];
	logic ocl_q;
	logic ocmd_q;

	logic signed [CW-1:0] goal_q [3];
	logic signed [CW-1:0] obst_q [3];
	logic [GAIN_W-1:0] gain_q;
	logic [GAIN_W-1:0] rad_q;

	logic signed [CW-1:0] p_q [3];
	logic signed [CW-1:0] s_q [3];
	logic signed [CW:0] w_q [3];
	logic signed [MW:0] v_q [3];
	logic [AW-1:0] d2_q;
	logic [2*GAIN_W-1:0] r2_q;
	logic [MW:0] mg_q;
	logic climb_q;
	logic pulse_q;

	logic signed [CW-1:0] pin [3];
	logic in_acc;
	logic out_free;
	logic climb_in;
	logic [CNT_W-1:0] n_last;
	logic harvest;
	logic [CW:0] w_mag;
	logic [MW:0] v_mag;
	logic rep;
	logic m2zero;
	logic [MW:0] rep_q;
	logic signed [MW:0] v_new;
	logic [FP-1:0] qdiv_q;
	logic signed [SW-1:0] s_sum;
	logic signed [CW-1:0] s_sat;

	unit_ctl_t ctl;
	logic [AW-1:0] op_a;
	logic [AW-1:0] op_b;
	logic [AW-1:0] u_acc;
	logic [AW-1:0] u_quo;
	logic [AW-1:0] u_root;

	assign pin[0] = pos.pos_x;
	assign pin[1] = pos.pos_y;
	assign pin[2] = pos.pos_z;

	assign pos.ready = (state_q == S_IDLE);
	assign in_acc = pos.valid && pos.ready;
	assign out_free = !oval_q || setpoint.ready;
	assign climb_in = pos.pos_z > CLIMB_Z;

	assign setpoint.valid = oval_q;
	assign setpoint.set_x = oset_q[0];
	assign setpoint.set_y = oset_q[1];
	assign setpoint.set_z = oset_q[2];
	assign setpoint.climbing = ocl_q;
	assign setpoint.send_mode_cmd = ocmd_q;
	assign setpoint.send_arm_cmd = ocmd_q;

	always_comb begin
		w_mag = w_q[ax_q][CW] ? CWP'(-w_q[ax_q]) : CWP'(w_q[ax_q]);
		v_mag = v_q[ax_q][MW] ? MWP'(-v_q[ax_q]) : MWP'(v_q[ax_q]);
		rep = (u_acc != '0) && (u_acc < AW'(r2_q));
		m2zero = (u_acc == '0);

		rep_q = MWP'(u_quo[MW-1:0]);
		v_new = w_q[ax_q][CW] ? v_q[ax_q] - $signed(rep_q) : v_q[ax_q] + $signed(rep_q);

		qdiv_q = u_quo[FP-1:0];
		s_sum = v_q[ax_q][MW] ? SW'(p_q[ax_q]) - $signed(SW'(qdiv_q))
			: SW'(p_q[ax_q]) + $signed(SW'(qdiv_q));
		if (s_sum > SMAX) begin
			s_sat = SMAX[CW-1:0];
		end else if (s_sum < SMIN) begin
			s_sat = SMIN[CW-1:0];
		end else begin
			s_sat = s_sum[CW-1:0];
		end
	end

	// Each arithmetic phase loads the unit, runs n_last steps, then takes the result.
	always_comb begin
		ctl.op = OP_MUL;
		ctl.clr = 1'b1;
		op_a = '0;
		op_b = '0;
		n_last = CNT_W'(MW);
		case (state_q)
			S_RSQ: begin
				op_a = AW'(rad_q);
				op_b = AW'(rad_q);
			end
			S_DSQ: begin
				op_a = AW'(w_mag);
				op_b = AW'(w_mag);
				ctl.clr = (ax_q == 2'd0);
			end
			S_RMUL: begin
				op_a = AW'(w_mag);
				op_b = AW'(gain_q);
			end
			S_RDIV: begin
				ctl.op = OP_DIV;
				op_a = d2_q;
				op_b = u_acc << F;
				n_last = CNT_W'(AW);
			end
			S_MSQ: begin
				op_a = AW'(v_mag);
				op_b = AW'(v_mag);
				ctl.clr = (ax_q == 2'd0);
			end
			S_SQRT: begin
				ctl.op = OP_SQRT;
				op_b = u_acc;
				n_last = CNT_W'(AW / 2);
			end
			S_QDIV: begin
				ctl.op = OP_DIV;
				op_a = AW'(mg_q);
				op_b = AW'(v_mag) << F;
				n_last = CNT_W'(AW);
			end
			default: begin
			end
		endcase
		harvest = (cnt_q == n_last + 1'b1);
		ctl.ld = (cnt_q == '0) && (state_q != S_IDLE) && (state_q != S_FINISH);
		ctl.stp = (cnt_q != '0) && !harvest;
	end

	pfs_serial_unit #(
		.AW(AW)
	) u_unit (
		.clk(clk),
		.ctl(ctl),
		.a(op_a),
		.b(op_b),
		.acc(u_acc),
		.quo(u_quo),
		.root(u_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q[0] <= '0;
			goal_q[1] <= '0;
			goal_q[2] <= GOAL_Z_RST;
			obst_q[0] <= '0;
			obst_q[1] <= '0;
			obst_q[2] <= OBST_Z_RST;
			gain_q <= GAIN_RST;
			rad_q <= RAD_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_GOAL_X: goal_q[0] <= wr_data[CW-1:0];
				REG_GOAL_Y: goal_q[1] <= wr_data[CW-1:0];
				REG_GOAL_Z: goal_q[2] <= wr_data[CW-1:0];
				REG_OBST_X: obst_q[0] <= wr_data[CW-1:0];
				REG_OBST_Y: obst_q[1] <= wr_data[CW-1:0];
				REG_OBST_Z: obst_q[2] <= wr_data[CW-1:0];
				REG_GAIN: gain_q <= wr_data[GAIN_W-1:0];
				REG_RADIUS: rad_q <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 3; i++) begin
				p_q[i] <= pin[i];
				w_q[i] <= CWP'(pin[i]) - CWP'(obst_q[i]);
				v_q[i] <= MWP'(goal_q[i]) - MWP'(pin[i]);
			end
			climb_q <= climb_in;
			pulse_q <= (tick_q == TICK_PULSE);
			if (climb_in) begin
				s_q[0] <= '0;
				s_q[1] <= '0;
				s_q[2] <= CLIMB_Z;
			end
		end
		if (harvest) begin
			case (state_q)
				S_RSQ: r2_q <= u_acc[2*GAIN_W-1:0];
				S_DSQ: d2_q <= u_acc;
				S_RDIV: v_q[ax_q] <= v_new;
				S_MSQ: begin
					if (ax_q == 2'd2 && m2zero) begin
						for (int i = 0; i < 3; i++) begin
							s_q[i] <= p_q[i];
						end
					end
				end
				S_SQRT: mg_q <= u_root[MW:0];
				S_QDIV: s_q[ax_q] <= s_sat;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ax_q <= '0;
			tick_q <= '0;
			oval_q <= 1'b0;
			oset_q[0] <= '0;
			oset_q[1] <= '0;
			oset_q[2] <= '0;
			ocl_q <= 1'b0;
			ocmd_q <= 1'b0;
		end else begin
			if (oval_q && setpoint.ready) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (tick_q != TICK_LAST) begin
							tick_q <= tick_q + 1'b1;
						end
						cnt_q <= '0;
						ax_q <= '0;
						state_q <= climb_in ? S_FINISH : S_RSQ;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						oval_q <= 1'b1;
						oset_q[0] <= s_q[0];
						oset_q[1] <= s_q[1];
						oset_q[2] <= s_q[2];
						ocl_q <= climb_q;
						ocmd_q <= pulse_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					if (!harvest) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
						case (state_q)
							S_RSQ: begin
								ax_q <= '0;
								state_q <= S_DSQ;
							end
							S_DSQ: begin
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= rep ? S_RMUL : S_MSQ;
								end else begin
									ax_q <= ax_q + 1'b1;
								end
							end
							S_RMUL: state_q <= S_RDIV;
							S_RDIV: begin
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= S_MSQ;
								end else begin
									ax_q <= ax_q + 1'b1;
									state_q <= S_RMUL;
								end
							end
							S_MSQ: begin
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= m2zero ? S_FINISH : S_SQRT;
								end else begin
									ax_q <= ax_q + 1'b1;
								end
							end
							S_SQRT: begin
								ax_q <= '0;
								state_q <= S_QDIV;
							end
							S_QDIV: begin
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= S_FINISH;
								end else begin
									ax_q <= ax_q + 1'b1;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	`PFS_ASSERT(a_climb_point, setpoint.valid && setpoint.climbing |-> setpoint.set_x == '0 && setpoint.set_y == '0 && setpoint.set_z == CLIMB_Z, "climb setpoint is not the fixed point")
	`PFS_ASSERT(a_cmd_pair, setpoint.valid |-> setpoint.send_mode_cmd == setpoint.send_arm_cmd, "mode and arm flags differ")
	`PFS_ASSERT(a_pulse_tick, setpoint.valid && setpoint.send_mode_cmd |-> tick_q == TICK_LAST, "command pulse without the tick count at its end")
	`PFS_ASSERT_NEXT(a_busy_after_accept, pos.valid && pos.ready, state_q != S_IDLE, "transfer accepted but sequencer stayed idle")

endmodule
